// File: sv/mnmp_pkg.sv
// ============================================================================
// mnmp_pkg
// Shared types and byte codes for the MIDI note message parser.
// ============================================================================
package mnmp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CHAN_W    = 4;
    localparam int KIND_W    = 2;
    localparam int OUT_DATA_W = 24;   // channel + note + velocity, padded to bytes

    // decode phase
    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_ON_1    = 4'd1,
        PH_ON_2    = 4'd2,
        PH_OFF_1   = 4'd3,
        PH_OFF_2   = 4'd4,
        PH_SYSEX   = 4'd5,
        PH_SKIP3_1 = 4'd6,
        PH_SKIP3_2 = 4'd7,
        PH_SKIP2_1 = 4'd8
    } phase_t;

    // held message kind
    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 2'd0,
        KIND_ON    = 2'd1,
        KIND_OFF   = 2'd2,
        KIND_SYSEX = 2'd3
    } kind_t;

    // status byte high nibbles
    localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
    localparam logic [3:0] ST_NOTE_ON   = 4'h9;
    localparam logic [3:0] ST_AFTERTCH  = 4'hA;
    localparam logic [3:0] ST_CTRL_CHG  = 4'hB;
    localparam logic [3:0] ST_PROG_CHG  = 4'hC;
    localparam logic [3:0] ST_CHAN_PRS  = 4'hD;
    localparam logic [3:0] ST_PITCH_BND = 4'hE;
    localparam logic [3:0] ST_SYSTEM    = 4'hF;

    localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
    localparam logic [BYTE_W-1:0] VEL_ZERO    = 8'h00;

endpackage

// File: sv/midi_note_message_parser.sv
// ============================================================================
// midi_note_message_parser
// Byte-wise MIDI decoder that tracks Note On / Note Off messages.
// ============================================================================
// Usage:
//   s_axis carries one received MIDI byte per request. Every accepted byte
//   produces exactly one request on m_axis: tlast flags a byte that just
//   completed a note on/off message, tuser is the held message kind, and
//   tdata holds the held channel, note number and velocity.
//   The decode state and the result register are both loaded at the edge
//   that accepts the byte. Throughput is one byte per cycle; the single result
//   register is refilled in the same cycle it is drained, so s_axis_tready only
//   drops while a result sits untaken.
//   When the receiver stalls (m_axis_tready low with a result pending) the
//   result holds and s_axis_tready is low, so no byte is lost.
//   Reset (rst_n low, asynchronous) returns the decoder to idle, clears the
//   held message to kind none / zeros and empties the result register.
//   No running status: a data byte seen while idle is not decoded (done = 0).
//   Status bytes inside a note message are stored as data; sysex skips all
//   bytes until F7.
// ============================================================================
module midi_note_message_parser (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tlast,   // message_done
    output logic [1:0]  m_axis_tuser,   // [1:0] message_kind
    output logic [23:0] m_axis_tdata    // [3:0] channel, [11:4] note_number,
                                        // [19:12] velocity, [23:20] zero
);

    // decode state
    mnmp_pkg::phase_t                  phase_reg,    phase_next;
    mnmp_pkg::kind_t                   kind_reg,     kind_next;
    logic [mnmp_pkg::CHAN_W-1:0]       channel_reg,  channel_next;
    logic [mnmp_pkg::BYTE_W-1:0]       note_reg,     note_next;
    logic [mnmp_pkg::BYTE_W-1:0]       velocity_reg, velocity_next;
    logic                              done_reg,     done_next;

    // result register
    logic                              out_valid_reg;
    logic                              out_last_reg;
    logic [mnmp_pkg::KIND_W-1:0]       out_user_reg;
    logic [mnmp_pkg::OUT_DATA_W-1:0]   out_data_reg;

    logic                              accept;
    logic [mnmp_pkg::BYTE_W-1:0]       rx;
    logic [3:0]                        rx_hi;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign rx_hi         = rx[7:4];

    // next decode state for the byte on the input
    always_comb
    begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        channel_next  = channel_reg;
        note_next     = note_reg;
        velocity_next = velocity_reg;
        done_next     = done_reg;
        case (phase_reg)
            mnmp_pkg::PH_IDLE:
            begin
                done_next = 1'b0;
                case (rx_hi)
                    mnmp_pkg::ST_NOTE_ON:
                    begin
                        phase_next   = mnmp_pkg::PH_ON_1;
                        kind_next    = mnmp_pkg::KIND_ON;
                        channel_next = rx[3:0];
                    end
                    mnmp_pkg::ST_NOTE_OFF:
                    begin
                        phase_next   = mnmp_pkg::PH_OFF_1;
                        kind_next    = mnmp_pkg::KIND_OFF;
                        channel_next = rx[3:0];
                    end
                    mnmp_pkg::ST_AFTERTCH, mnmp_pkg::ST_CTRL_CHG,
                    mnmp_pkg::ST_PITCH_BND:
                        phase_next = mnmp_pkg::PH_SKIP3_1;
                    mnmp_pkg::ST_PROG_CHG, mnmp_pkg::ST_CHAN_PRS:
                        phase_next = mnmp_pkg::PH_SKIP2_1;
                    mnmp_pkg::ST_SYSTEM:
                    begin
                        if (rx == mnmp_pkg::SYSEX_START)
                        begin
                            phase_next = mnmp_pkg::PH_SYSEX;
                            kind_next  = mnmp_pkg::KIND_SYSEX;
                        end
                        else
                        begin
                            phase_next = mnmp_pkg::PH_IDLE;
                        end
                    end
                    default:
                        phase_next = mnmp_pkg::PH_IDLE;
                endcase
            end
            mnmp_pkg::PH_ON_1:
            begin
                note_next  = rx;
                phase_next = mnmp_pkg::PH_ON_2;
            end
            mnmp_pkg::PH_ON_2:
            begin
                velocity_next = rx;
                if (rx == mnmp_pkg::VEL_ZERO)
                begin
                    kind_next = mnmp_pkg::KIND_OFF;   // on with zero velocity
                end
                done_next  = 1'b1;
                phase_next = mnmp_pkg::PH_IDLE;
            end
            mnmp_pkg::PH_OFF_1:
            begin
                note_next  = rx;
                phase_next = mnmp_pkg::PH_OFF_2;
            end
            mnmp_pkg::PH_OFF_2:
            begin
                velocity_next = rx;
                done_next     = 1'b1;
                phase_next    = mnmp_pkg::PH_IDLE;
            end
            mnmp_pkg::PH_SYSEX:
            begin
                if (rx == mnmp_pkg::SYSEX_END)
                begin
                    phase_next = mnmp_pkg::PH_IDLE;
                end
            end
            mnmp_pkg::PH_SKIP3_1:
                phase_next = mnmp_pkg::PH_SKIP3_2;
            default:   // last skipped byte, or an unused code
                phase_next = mnmp_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mnmp_pkg::PH_IDLE;
            kind_reg     <= mnmp_pkg::KIND_NONE;
            channel_reg  <= '0;
            note_reg     <= '0;
            velocity_reg <= '0;
            done_reg     <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            channel_reg  <= channel_next;
            note_reg     <= note_next;
            velocity_reg <= velocity_next;
            done_reg     <= done_next;
        end
    end

    // result register: valid is control, payload loads on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_last_reg <= done_next;
            out_user_reg <= kind_next;
            out_data_reg <= {4'b0000, velocity_next, note_next, channel_next};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tdata  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a completed message is always a note on or note off
    a_done_is_note: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser == mnmp_pkg::KIND_ON || m_axis_tuser == mnmp_pkg::KIND_OFF))
        else $error("done flagged on a non-note message");

    // every accepted byte shows up as a result in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted byte produced no result");

    // a byte taken while idle never completes a message
    a_idle_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (phase_reg == mnmp_pkg::PH_IDLE) |=> !m_axis_tlast)
        else $error("done set by a status byte");

    // a note message always passes through its second data byte phase
    a_done_from_second: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done_next |->
            (phase_reg == mnmp_pkg::PH_ON_2 || phase_reg == mnmp_pkg::PH_OFF_2))
        else $error("done set outside the velocity phase");

endmodule

// File: bench/tb_midi_note_message_parser.sv
// ============================================================================
// tb_midi_note_message_parser
// Self-checking bench for the byte-wise MIDI note message decoder.
// A short scripted byte sequence covers idle bytes, note on/off with channel
// and value extremes, zero-velocity note on, skipped channel messages, sysex
// and status bytes taken as data. A long run of random messages follows.
// Every result request is checked field by field against its scripted value or
// an in-bench decoder model. Both stream sides idle at random, and the receiver
// holds off once for a long stretch to back up the input.
// ============================================================================
module tb_midi_note_message_parser;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RANDOM_BYTES = 400;
    localparam int  CALM_AFTER   = 340;      // no idling past this many bytes
    localparam int  HOLD_CYCLES  = 64;       // long receiver hold-off
    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  DRAIN_CYCLES = 4;        // settle time after the last result

    // one decoded result as seen on m_axis
    typedef struct packed {
        logic            done;
        mnmp_pkg::kind_t kind;
        logic [3:0]      chan;
        logic [7:0]      note;
        logic [7:0]      vel;
    } note_msg_t;

    // scripted byte; want is used only when fixed is set
    typedef struct packed {
        logic [7:0] data;
        logic       fixed;
        note_msg_t  want;
    } script_row_t;

    localparam note_msg_t NOTHING_HELD = '{1'b0, mnmp_pkg::KIND_NONE, 4'h0, 8'h00, 8'h00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // [7:0] data_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        m_axis_tlast;             // message_done
    logic [1:0]  m_axis_tuser;             // [1:0] message_kind
    logic [23:0] m_axis_tdata;             // [3:0] channel, [11:4] note_number,
                                           // [19:12] velocity, [23:20] zero

    // decoder model state
    mnmp_pkg::phase_t dec_phase = mnmp_pkg::PH_IDLE;
    mnmp_pkg::kind_t  dec_kind  = mnmp_pkg::KIND_NONE;
    logic [3:0]       dec_chan  = 4'h0;
    logic [7:0]       dec_note  = 8'h00;
    logic [7:0]       dec_vel   = 8'h00;
    logic             dec_done  = 1'b0;

    note_msg_t  expected_msgs[$];
    int         errors = 0;
    int         cycles = 0;
    bit         calm = 1'b0;               // set for the tail: no idling
    bit         hold_req = 1'b0;           // ask receiver for the long hold-off
    bit         hold_taken = 1'b0;

    // Scripted bytes. Fixed rows have results obvious from the protocol;
    // the rest go through the model.
    script_row_t script [0:27] = '{
        '{8'h00, 1'b1, NOTHING_HELD},                          // data while idle
        '{8'hFF, 1'b1, NOTHING_HELD},                          // system byte, idle
        '{8'h9F, 1'b1, '{1'b0, mnmp_pkg::KIND_ON,  4'hF, 8'h00, 8'h00}}, // note on, ch 15
        '{8'hFF, 1'b1, '{1'b0, mnmp_pkg::KIND_ON,  4'hF, 8'hFF, 8'h00}}, // status as note
        '{8'h80, 1'b1, '{1'b1, mnmp_pkg::KIND_ON,  4'hF, 8'hFF, 8'h80}}, // status as velocity
        '{8'h90, 1'b1, '{1'b0, mnmp_pkg::KIND_ON,  4'h0, 8'hFF, 8'h80}}, // note on, ch 0
        '{8'h00, 1'b1, '{1'b0, mnmp_pkg::KIND_ON,  4'h0, 8'h00, 8'h80}},
        '{8'h00, 1'b1, '{1'b1, mnmp_pkg::KIND_OFF, 4'h0, 8'h00, 8'h00}}, // vel 0 -> note off
        '{8'h8A, 1'b0, NOTHING_HELD},                          // note off
        '{8'h3C, 1'b0, NOTHING_HELD},
        '{8'h40, 1'b0, NOTHING_HELD},
        '{8'hA5, 1'b0, NOTHING_HELD},                          // aftertouch
        '{8'h12, 1'b0, NOTHING_HELD},
        '{8'h34, 1'b0, NOTHING_HELD},
        '{8'hB0, 1'b0, NOTHING_HELD},                          // control change
        '{8'h90, 1'b0, NOTHING_HELD},                          // skipped, not a status
        '{8'h91, 1'b0, NOTHING_HELD},
        '{8'hE3, 1'b0, NOTHING_HELD},                          // pitch bend
        '{8'h00, 1'b0, NOTHING_HELD},
        '{8'h7F, 1'b0, NOTHING_HELD},
        '{8'hC1, 1'b0, NOTHING_HELD},                          // program change
        '{8'h90, 1'b0, NOTHING_HELD},
        '{8'hD2, 1'b0, NOTHING_HELD},                          // channel pressure
        '{8'h20, 1'b0, NOTHING_HELD},
        '{8'hF0, 1'b0, NOTHING_HELD},                          // sysex start
        '{8'h90, 1'b0, NOTHING_HELD},                          // ignored in sysex
        '{8'hF7, 1'b0, NOTHING_HELD},                          // sysex end
        '{8'hF1, 1'b0, NOTHING_HELD}                           // other system byte
    };

    midi_note_message_parser u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 0;
    end

    // Model of the decoder: advances the held message by one byte.
    function automatic note_msg_t decode_byte(input logic [7:0] b);
        note_msg_t r;
        case (dec_phase)
            mnmp_pkg::PH_IDLE:
            begin
                dec_done = 1'b0;
                case (b[7:4])
                    mnmp_pkg::ST_NOTE_ON:
                    begin
                        dec_phase = mnmp_pkg::PH_ON_1;
                        dec_kind  = mnmp_pkg::KIND_ON;
                        dec_chan  = b[3:0];
                    end
                    mnmp_pkg::ST_NOTE_OFF:
                    begin
                        dec_phase = mnmp_pkg::PH_OFF_1;
                        dec_kind  = mnmp_pkg::KIND_OFF;
                        dec_chan  = b[3:0];
                    end
                    mnmp_pkg::ST_AFTERTCH, mnmp_pkg::ST_CTRL_CHG,
                    mnmp_pkg::ST_PITCH_BND:
                        dec_phase = mnmp_pkg::PH_SKIP3_1;
                    mnmp_pkg::ST_PROG_CHG, mnmp_pkg::ST_CHAN_PRS:
                        dec_phase = mnmp_pkg::PH_SKIP2_1;
                    default:
                    begin
                        // data bytes and system bytes other than sysex start
                        if (b == mnmp_pkg::SYSEX_START)
                        begin
                            dec_phase = mnmp_pkg::PH_SYSEX;
                            dec_kind  = mnmp_pkg::KIND_SYSEX;
                        end
                        else
                            dec_phase = mnmp_pkg::PH_IDLE;
                    end
                endcase
            end
            mnmp_pkg::PH_ON_1:
            begin
                dec_note  = b;
                dec_phase = mnmp_pkg::PH_ON_2;
            end
            mnmp_pkg::PH_ON_2:
            begin
                dec_vel = b;
                if (b == mnmp_pkg::VEL_ZERO)
                    dec_kind = mnmp_pkg::KIND_OFF;
                dec_done  = 1'b1;
                dec_phase = mnmp_pkg::PH_IDLE;
            end
            mnmp_pkg::PH_OFF_1:
            begin
                dec_note  = b;
                dec_phase = mnmp_pkg::PH_OFF_2;
            end
            mnmp_pkg::PH_OFF_2:
            begin
                dec_vel   = b;
                dec_done  = 1'b1;
                dec_phase = mnmp_pkg::PH_IDLE;
            end
            mnmp_pkg::PH_SYSEX:
            begin
                if (b == mnmp_pkg::SYSEX_END)
                    dec_phase = mnmp_pkg::PH_IDLE;
            end
            mnmp_pkg::PH_SKIP3_1: dec_phase = mnmp_pkg::PH_SKIP3_2;
            default:              dec_phase = mnmp_pkg::PH_IDLE;
        endcase
        r = '{dec_done, dec_kind, dec_chan, dec_note, dec_vel};
        return r;
    endfunction

    // Offer one byte, wait for the request to be taken, queue its result.
    // Called at a rising edge; returns at the edge that accepted the byte.
    task automatic send_byte(input logic [7:0] b, input logic fixed, input note_msg_t want);
        note_msg_t predicted;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = decode_byte(b);
        expected_msgs.push_back(fixed ? want : predicted);
    endtask

    task automatic send_data(input logic [7:0] b);
        send_byte(b, 1'b0, NOTHING_HELD);
    endtask

    // data byte: mostly 7-bit MIDI data, sometimes any value
    function automatic logic [7:0] any_data();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    // Stimulus
    initial
    begin
        int         sent;
        int         pick;
        int         len;
        logic [3:0] nib;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_byte(script[i].data, script[i].fixed, script[i].want);

        hold_req = 1'b1;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            calm = (sent >= CALM_AFTER);
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // note on, one in five with zero velocity
                send_data({mnmp_pkg::ST_NOTE_ON, 4'($urandom_range(0, 15))});
                send_data(any_data());
                send_data(($urandom_range(0, 4) == 0) ? mnmp_pkg::VEL_ZERO : any_data());
                sent += 3;
            end
            else if (pick < 50)
            begin
                send_data({mnmp_pkg::ST_NOTE_OFF, 4'($urandom_range(0, 15))});
                send_data(any_data());
                send_data(any_data());
                sent += 3;
            end
            else if (pick < 60)
            begin
                len = $urandom_range(0, 2);
                nib = (len == 0) ? mnmp_pkg::ST_AFTERTCH :
                      (len == 1) ? mnmp_pkg::ST_CTRL_CHG : mnmp_pkg::ST_PITCH_BND;
                send_data({nib, 4'($urandom_range(0, 15))});
                send_data(any_data());
                send_data(any_data());
                sent += 3;
            end
            else if (pick < 70)
            begin
                nib = $urandom_range(0, 1) ? mnmp_pkg::ST_PROG_CHG : mnmp_pkg::ST_CHAN_PRS;
                send_data({nib, 4'($urandom_range(0, 15))});
                send_data(any_data());
                sent += 2;
            end
            else if (pick < 80)
            begin
                // sysex with random body; a random F7 may end it early
                send_data(mnmp_pkg::SYSEX_START);
                len = $urandom_range(0, 6);
                repeat (len)
                    send_data(8'($urandom_range(0, 255)));
                send_data(mnmp_pkg::SYSEX_END);
                sent += len + 2;
            end
            else if (pick < 90)
            begin
                // a note message cut short, then whatever follows is data
                send_data({$urandom_range(0, 1) ? mnmp_pkg::ST_NOTE_ON : mnmp_pkg::ST_NOTE_OFF,
                           4'($urandom_range(0, 15))});
                send_data(8'($urandom_range(0, 255)));
                sent += 2;
            end
            else
                // noise; never counted in sent
                send_data(8'($urandom_range(0, 255)));
        end
        s_axis_tvalid <= 1'b0;

        while (expected_msgs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("** midi_note_message_parser: PASSED **");
        else
            $display("** midi_note_message_parser: FAILED **");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off, no stalls in the tail.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic report(input string what, input int want, input int got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, what, want, got);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        note_msg_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_msgs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0h/%0h/%0h",
                         $realtime, m_axis_tlast, m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                want = expected_msgs.pop_front();
                if (m_axis_tlast !== want.done)
                    report("message_done", want.done, m_axis_tlast);
                if (m_axis_tuser !== want.kind)
                    report("message_kind", want.kind, m_axis_tuser);
                if (m_axis_tdata[3:0] !== want.chan)
                    report("channel", want.chan, m_axis_tdata[3:0]);
                if (m_axis_tdata[11:4] !== want.note)
                    report("note_number", want.note, m_axis_tdata[11:4]);
                if (m_axis_tdata[19:12] !== want.vel)
                    report("velocity", want.vel, m_axis_tdata[19:12]);
                if (m_axis_tdata[23:20] !== 4'h0)
                    report("tdata padding", 0, m_axis_tdata[23:20]);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still expected", $realtime,
                     expected_msgs.size());
            $display("** midi_note_message_parser: FAILED **");
            $finish;
        end
    end

endmodule
